// ===== rtl/cstl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cstl_pkg;

  localparam int KW_COUNT        = 9;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam logic [12:0] TOKEN_LIMIT_RST = 13'd256;

  // token codes
  localparam logic [5:0] TOK_END    = 6'd0;
  localparam logic [5:0] TOK_EQ_EQ  = 6'd10;
  localparam logic [5:0] TOK_NE     = 6'd11;
  localparam logic [5:0] TOK_GE     = 6'd12;
  localparam logic [5:0] TOK_LE     = 6'd13;
  localparam logic [5:0] TOK_INC    = 6'd14;
  localparam logic [5:0] TOK_DEC    = 6'd15;
  localparam logic [5:0] TOK_ADD_EQ = 6'd16;
  localparam logic [5:0] TOK_SUB_EQ = 6'd17;
  localparam logic [5:0] TOK_MUL_EQ = 6'd18;
  localparam logic [5:0] TOK_GT     = 6'd19;
  localparam logic [5:0] TOK_LT     = 6'd20;
  localparam logic [5:0] TOK_ASSIGN = 6'd21;
  localparam logic [5:0] TOK_PLUS   = 6'd22;
  localparam logic [5:0] TOK_MINUS  = 6'd23;
  localparam logic [5:0] TOK_STAR   = 6'd24;
  localparam logic [5:0] TOK_SLASH  = 6'd25;
  localparam logic [5:0] TOK_LPAREN = 6'd26;
  localparam logic [5:0] TOK_RPAREN = 6'd27;
  localparam logic [5:0] TOK_LBRACE = 6'd28;
  localparam logic [5:0] TOK_RBRACE = 6'd29;
  localparam logic [5:0] TOK_NUMBER = 6'd30;
  localparam logic [5:0] TOK_IDENT  = 6'd31;
  localparam logic [5:0] TOK_SEMI   = 6'd54;
  localparam logic [5:0] TOK_COLON  = 6'd55;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_NUMBER = 2'd1,
    MODE_IDENT  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_EQ    = 3'd1,
    OP_BANG  = 3'd2,
    OP_GT    = 3'd3,
    OP_LT    = 3'd4,
    OP_PLUS  = 3'd5,
    OP_MINUS = 3'd6,
    OP_STAR  = 3'd7
  } op_t;

  // all words caused by one byte; the end marker, if any, is the last slot used
  typedef struct packed {
    logic [1:0]      num;
    logic            eot;
    logic [2:0][5:0] code;
  } bundle_t;

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {["0":"9"]};
  endfunction

  function automatic logic is_ident_start(input logic [7:0] b);
    return (b inside {["a":"z"], ["A":"Z"]}) || (b == "_");
  endfunction

  function automatic logic is_ident_char(input logic [7:0] b);
    return is_ident_start(b) || is_digit(b);
  endfunction

  function automatic op_t op_of(input logic [7:0] b);
    op_t o;
    case (b)
      "=":     o = OP_EQ;
      "!":     o = OP_BANG;
      ">":     o = OP_GT;
      "<":     o = OP_LT;
      "+":     o = OP_PLUS;
      "-":     o = OP_MINUS;
      "*":     o = OP_STAR;
      default: o = OP_NONE;
    endcase
    return o;
  endfunction

  // lone '!' has no single-character token
  function automatic logic [5:0] op_single(input op_t op);
    logic [5:0] c;
    case (op)
      OP_EQ:    c = TOK_ASSIGN;
      OP_GT:    c = TOK_GT;
      OP_LT:    c = TOK_LT;
      OP_PLUS:  c = TOK_PLUS;
      OP_MINUS: c = TOK_MINUS;
      OP_STAR:  c = TOK_STAR;
      default:  c = TOK_END;
    endcase
    return c;
  endfunction

  function automatic logic [5:0] pair_code(input op_t op, input logic [7:0] b);
    logic [5:0] c;
    c = TOK_END;
    case (op)
      OP_EQ:    if (b == "=") c = TOK_EQ_EQ;
      OP_BANG:  if (b == "=") c = TOK_NE;
      OP_GT:    if (b == "=") c = TOK_GE;
      OP_LT:    if (b == "=") c = TOK_LE;
      OP_PLUS:  if (b == "+") c = TOK_INC; else if (b == "=") c = TOK_ADD_EQ;
      OP_MINUS: if (b == "-") c = TOK_DEC; else if (b == "=") c = TOK_SUB_EQ;
      OP_STAR:  if (b == "=") c = TOK_MUL_EQ;
      default:  c = TOK_END;
    endcase
    return c;
  endfunction

  function automatic logic [5:0] punct_code(input logic [7:0] b);
    logic [5:0] c;
    case (b)
      "/":     c = TOK_SLASH;
      "(":     c = TOK_LPAREN;
      ")":     c = TOK_RPAREN;
      "{":     c = TOK_LBRACE;
      "}":     c = TOK_RBRACE;
      ";":     c = TOK_SEMI;
      ":":     c = TOK_COLON;
      default: c = TOK_END;
    endcase
    return c;
  endfunction

  // keyword spelling, first character in the top byte, zero padded
  function automatic logic [47:0] kw_text(input logic [3:0] k);
    logic [47:0] t;
    case (k)
      4'd0:    t = "switch";
      4'd1:    t = {"while", 8'h00};
      4'd2:    t = {"break", 8'h00};
      4'd3:    t = {"case", 16'h0000};
      4'd4:    t = {"else", 16'h0000};
      4'd5:    t = {"void", 16'h0000};
      4'd6:    t = {"for", 24'h000000};
      4'd7:    t = {"int", 24'h000000};
      4'd8:    t = {"if", 32'h00000000};
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [2:0] kw_len(input logic [3:0] k);
    logic [2:0] l;
    case (k)
      4'd0:                l = 3'd6;
      4'd1, 4'd2:          l = 3'd5;
      4'd3, 4'd4, 4'd5:    l = 3'd4;
      4'd6, 4'd7:          l = 3'd3;
      4'd8:                l = 3'd2;
      default:             l = 3'd0;
    endcase
    return l;
  endfunction

  // zero beyond the keyword's end never matches an identifier character
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] p);
    logic [47:0] t;
    logic [7:0]  c;
    t = kw_text(k);
    c = 8'h00;
    if (p < 3'd6) c = t[8 * (5 - int'(p)) +: 8];
    return c;
  endfunction

  function automatic logic [KW_COUNT-1:0] kw_step(input logic [KW_COUNT-1:0] cand,
                                                  input logic [2:0] len,
                                                  input logic [7:0] b);
    logic [KW_COUNT-1:0] c;
    c = cand;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (kw_char(4'(k), len) != b) c[k] = 1'b0;
    end
    return c;
  endfunction

  function automatic logic [5:0] ident_code(input logic [KW_COUNT-1:0] cand,
                                            input logic [2:0] len);
    logic [5:0] c;
    c = TOK_IDENT;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (cand[k] && (len == kw_len(4'(k)))) c = 6'(k + 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cstl_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cstl_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           take,
  input  wire logic [7:0]     text_byte,
  input  wire logic           end_of_text,
  input  wire logic [12:0]    token_limit,
  output cstl_pkg::bundle_t   bundle,
  output logic                bundle_valid
);
  import cstl_pkg::*;

  mode_t               mode_r, mode_nxt;
  op_t                 pend_r, pend_nxt;
  logic [KW_COUNT-1:0] cand_r, cand_nxt;
  logic [2:0]          len_r, len_nxt;
  logic [12:0]         cnt_r, cnt_nxt;

  logic [1:0] n_v;
  logic [5:0] t0, t1, pc, sc, punct;
  logic       done;
  op_t        op_in;
  logic       a0, a1;
  logic [1:0] e_cnt;

  // lexing: next state and the list of ordinary tokens from this byte
  always_comb begin
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    cand_nxt = cand_r;
    len_nxt  = len_r;
    n_v      = 2'd0;
    t0       = TOK_END;
    t1       = TOK_END;
    done     = 1'b0;
    pc       = TOK_END;
    sc       = TOK_END;
    op_in    = op_of(text_byte);
    punct    = punct_code(text_byte);

    if (mode_r == MODE_IDENT) begin
      if (is_ident_char(text_byte)) begin
        cand_nxt = kw_step(cand_r, len_r, text_byte);
        if (len_r != 3'd7) len_nxt = len_r + 3'd1;
        done = 1'b1;
      end else begin
        t0       = ident_code(cand_r, len_r);
        n_v      = 2'd1;
        mode_nxt = MODE_IDLE;
      end
    end else if (mode_r == MODE_NUMBER) begin
      if (is_digit(text_byte)) done = 1'b1;
      else mode_nxt = MODE_IDLE;
    end

    // an identifier and a held operator never coexist
    if (!done && pend_r != OP_NONE) begin
      pc       = pair_code(pend_r, text_byte);
      sc       = op_single(pend_r);
      pend_nxt = OP_NONE;
      if (pc != TOK_END) begin
        t0   = pc;
        n_v  = 2'd1;
        done = 1'b1;
      end else if (sc != TOK_END) begin
        t0  = sc;
        n_v = 2'd1;
      end
    end

    if (!done) begin
      if (op_in != OP_NONE) begin
        pend_nxt = op_in;
      end else if (punct != TOK_END) begin
        if (n_v == 2'd0) t0 = punct; else t1 = punct;
        n_v = n_v + 2'd1;
      end else if (is_digit(text_byte)) begin
        mode_nxt = MODE_NUMBER;
        if (n_v == 2'd0) t0 = TOK_NUMBER; else t1 = TOK_NUMBER;
        n_v = n_v + 2'd1;
      end else if (is_ident_start(text_byte)) begin
        mode_nxt = MODE_IDENT;
        cand_nxt = kw_step({KW_COUNT{1'b1}}, 3'd0, text_byte);
        len_nxt  = 3'd1;
      end
    end

    if (end_of_text) begin
      if (mode_nxt == MODE_IDENT) begin
        if (n_v == 2'd0) t0 = ident_code(cand_nxt, len_nxt);
        else t1 = ident_code(cand_nxt, len_nxt);
        n_v = n_v + 2'd1;
      end else if (pend_nxt != OP_NONE && op_single(pend_nxt) != TOK_END) begin
        if (n_v == 2'd0) t0 = op_single(pend_nxt); else t1 = op_single(pend_nxt);
        n_v = n_v + 2'd1;
      end
      mode_nxt = MODE_IDLE;
      pend_nxt = OP_NONE;
      cand_nxt = '0;
      len_nxt  = 3'd0;
    end
  end

  // token limit; tokens pass as a prefix, the end marker always goes
  always_comb begin
    a0      = cnt_r < token_limit;
    a1      = ({1'b0, cnt_r} + 14'd1) < {1'b0, token_limit};
    e_cnt   = 2'((n_v >= 2'd1) && a0) + 2'((n_v >= 2'd2) && a1);
    bundle.eot  = end_of_text;
    bundle.num  = e_cnt + 2'(end_of_text);
    bundle.code[0] = (e_cnt >= 2'd1) ? t0 : TOK_END;
    bundle.code[1] = (e_cnt >= 2'd2) ? t1 : TOK_END;
    bundle.code[2] = TOK_END;
    bundle_valid   = take && (bundle.num != 2'd0);
    cnt_nxt        = end_of_text ? 13'd0 : cnt_r + 13'(e_cnt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      pend_r <= OP_NONE;
      cand_r <= '0;
      len_r  <= 3'd0;
      cnt_r  <= 13'd0;
    end else if (take) begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
      cand_r <= cand_nxt;
      len_r  <= len_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_text_clears: assert property (@(posedge clk) disable iff (!rst_n)
    take && end_of_text |=> cnt_r == 13'd0 && mode_r == MODE_IDLE && pend_r == OP_NONE)
    else $error("text state not cleared after final byte");

  a_ident_no_op: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_IDENT |-> pend_r == OP_NONE)
    else $error("operator held inside identifier");

endmodule

`default_nettype wire

// ===== rtl/cstl_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cstl_queue #(
  parameter int DEPTH = cstl_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire cstl_pkg::bundle_t push_data,
  input  wire logic              pop,
  output cstl_pkg::bundle_t      head,
  output logic                   empty,
  output logic                   full
);
  import cstl_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t       slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == CW'(DEPTH));
  assign head  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    if (push && !pop)      count_nxt = count_r + CW'(1);
    else if (pop && !push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue underflow");

endmodule

`default_nettype wire

// ===== rtl/cstl_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cstl_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cstl_pkg::bundle_t head,
  input  wire logic              empty,
  output logic                   pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [7:0]             out_tdata,
  output logic                   out_tlast
);
  import cstl_pkg::*;

  bundle_t    hold_r, hold_nxt;
  logic       busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       final_slot;
  logic       slot_done;
  logic [5:0] code;

  assign final_slot = (idx_r == hold_r.num - 2'd1);
  assign slot_done  = busy_r && out_tready;
  assign pop        = !empty && (!busy_r || (slot_done && final_slot));

  always_comb begin
    hold_nxt = hold_r;
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (pop) begin
      hold_nxt = head;
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end else if (slot_done) begin
      if (final_slot) busy_nxt = 1'b0;
      else idx_nxt = idx_r + 2'd1;
    end
  end

  always_comb begin
    case (idx_r)
      2'd0:    code = hold_r.code[0];
      2'd1:    code = hold_r.code[1];
      default: code = hold_r.code[2];
    endcase
    out_tvalid = busy_r;
    out_tdata  = {2'b00, code};
    out_tlast  = busy_r && hold_r.eot && final_slot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

  a_idx_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r < hold_r.num)
    else $error("slot index past end of word group");

  a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tlast |-> out_tdata[5:0] == TOK_END)
    else $error("last flag on a non end-marker word");

endmodule

`default_nettype wire

// ===== rtl/c_subset_token_lexer_top.sv =====
// Token lexer for a small C subset.
// Input stream: one source byte per word on in_tdata, in_tlast on the final
// byte of a text. Output stream: one token code per word on out_tdata,
// out_tlast set only on the end marker (code 0) that closes each text.
// cfg_data sets the per-text token limit (reset value 256); write it only
// while no text is in flight. cfg_ready is always high.
// A byte yields zero to three words. The lexer front classifies a byte
// combinationally as it is taken and pushes its words as one group into a
// small queue; the output stage sends one word per cycle from that queue
// while out_tready is high. A byte's words pass through a queue slot and
// then the output holding register. Throughput: one byte per cycle if the
// queue has room; the output stage sets the sustained rate.
// When the receiver stalls, the queue fills and in_tready drops; nothing
// is lost. Reset clears the lexer state, the queue and the output stage,
// and restores the token limit to 256.
`timescale 1ns / 1ps
`default_nettype none

module c_subset_token_lexer_top #(
  parameter int QUEUE_DEPTH = cstl_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] text_byte
  input  wire logic        in_tlast,   // end_of_text
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [5:0] token_code, [7:6] zero
  output logic             out_tlast,  // last_token
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [12:0] cfg_data    // token_limit
);
  import cstl_pkg::*;

  logic [12:0] limit_r, limit_nxt;
  logic        take;
  bundle_t     grp;
  logic        grp_valid;
  bundle_t     q_head;
  logic        q_empty, q_full, q_pop;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign take      = in_tvalid && in_tready;
  assign limit_nxt = (cfg_valid && cfg_ready) ? cfg_data : limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= TOKEN_LIMIT_RST;
    else        limit_r <= limit_nxt;
  end

  cstl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .text_byte    (in_tdata),
    .end_of_text  (in_tlast),
    .token_limit  (limit_r),
    .bundle       (grp),
    .bundle_valid (grp_valid)
  );

  cstl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (grp_valid),
    .push_data (grp),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  cstl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
